// ===== src/rtks_pkg.sv =====
`default_nettype none

package rtks_pkg;

	// fixed field widths
	localparam int VALUE_W = 32;
	localparam int SUM_W   = 39;
	localparam int CFG_W   = 7;

	// defaults
	localparam int             STORE_SIZE_DEF = 64;
	localparam logic [CFG_W-1:0] CFG_RESET    = 7'd1;

	// sign extension of a sample to the accumulator width
	function automatic logic signed [SUM_W-1:0] widen(input logic signed [VALUE_W-1:0] x);
		widen = {{(SUM_W - VALUE_W){x[VALUE_W-1]}}, x};
	endfunction

endpackage

`default_nettype wire

// ===== src/rtks_in_if.sv =====
`default_nettype none

interface rtks_in_if;
	import rtks_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] sample_value;
	logic                      start_group;

	modport source (output valid, output sample_value, output start_group, input ready);
	modport sink   (input valid, input sample_value, input start_group, output ready);
endinterface

`default_nettype wire

// ===== src/rtks_out_if.sv =====
`default_nettype none

interface rtks_out_if;
	import rtks_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] prior_sum;

	modport source (output valid, output prior_sum, input ready);
	modport sink   (input valid, input prior_sum, output ready);
endinterface

`default_nettype wire

// ===== src/rtks_ram.sv =====
`default_nettype none

module rtks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/running_top_k_sum_top.sv =====
`default_nettype none

// Running top-k sum. For each sample beat the block returns, on the sums channel,
// the sum of the largest top_count samples admitted so far in the current group
// (a beat with start_group set first empties the group), then admits the sample:
// it is added while fewer than top_count samples are held, otherwise it replaces
// the held minimum only if strictly larger. top_count above STORE_SIZE acts as
// STORE_SIZE. Held samples live in a binary min-heap split over two RAM banks
// (even and odd heap positions), so both children of a node are read together.
// One sample is taken at a time: samples.ready stays low until the heap update is
// done. An insert sifts up and a replacement, after reading and comparing the
// root, sifts down, walking at most ceil(log2(STORE_SIZE)) heap levels; each
// level costs a RAM read and a compare. The result beat waits in an
// output register and does not hold up the heap update.
module running_top_k_sum_top #(
	parameter int STORE_SIZE = rtks_pkg::STORE_SIZE_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [rtks_pkg::CFG_W-1:0] cfg_wr_data,
	rtks_in_if.sink                         samples,
	rtks_out_if.source                      sums
);
	import rtks_pkg::*;

	localparam int AW  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
	localparam int CW  = $clog2(STORE_SIZE + 1);
	localparam int XW  = AW + 2;
	localparam int LW  = (CW > CFG_W) ? CW : CFG_W;
	localparam int BD  = (STORE_SIZE + 1) / 2;
	localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

	typedef enum logic [2:0] {
		IDLE, SU_RD, SU_CMP, RT_RD, RT_CMP, SD_RD, SD_CMP
	} state_t;

	state_t                    state_q;
	logic [CFG_W-1:0]          top_q;
	logic [CW-1:0]             count_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [VALUE_W-1:0] v_q;
	logic [AW-1:0]             hole_q;
	logic [AW-1:0]             par_q;
	logic                      c2v_q;
	logic                      out_valid_q;
	logic signed [SUM_W-1:0]   prior_q;

	// RAM ports
	logic                      we0, we1;
	logic [BAW-1:0]            waddr;
	logic [BAW-1:0]            raddr0, raddr1;
	logic signed [VALUE_W-1:0] rd0, rd1;
	logic                      wr_en;
	logic [AW-1:0]             wr_idx;
	logic signed [VALUE_W-1:0] wr_data;

	// accept-time values
	logic                      accept;
	logic [CW-1:0]             base_cnt;
	logic signed [SUM_W-1:0]   base_sum;
	logic [LW-1:0]             top_x, size_x, limit_x;
	logic                      has_room;

	// heap walk helpers
	logic [XW-1:0]             c1, c2, count_x;
	logic [AW-1:0]             parent;
	logic [AW:0]               hole_p1;
	logic signed [VALUE_W-1:0] par_data;
	logic                      pick_right;
	logic signed [VALUE_W-1:0] small_data;
	logic [AW-1:0]             small_idx;

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = (state_q == IDLE) && (!out_valid_q || sums.ready);
	assign sums.valid    = out_valid_q;
	assign sums.prior_sum = prior_q;

	// group start and effective limit
	always_comb begin
		base_cnt = samples.start_group ? '0 : count_q;
		base_sum = samples.start_group ? '0 : sum_q;
		top_x    = LW'(top_q);
		size_x   = LW'(STORE_SIZE);
		limit_x  = (top_x > size_x) ? size_x : top_x;
		has_room = LW'(base_cnt) < limit_x;
	end

	// child and parent positions of the current hole
	always_comb begin
		c1         = {1'b0, hole_q, 1'b1};
		c2         = c1 + XW'(1);
		count_x    = XW'(count_q);
		parent     = AW'((hole_q - AW'(1)) >> 1);
		hole_p1    = {1'b0, hole_q} + (AW+1)'(1);
		par_data   = par_q[0] ? rd1 : rd0;
		pick_right = c2v_q && (rd0 < rd1);
		small_data = pick_right ? rd0 : rd1;
		small_idx  = pick_right ? AW'(c2) : AW'(c1);
	end

	// RAM address and write selection
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = hole_q;
		wr_data = v_q;
		raddr0  = '0;
		raddr1  = '0;
		case (state_q)
			SU_RD: begin
				if (hole_q == '0) begin
					wr_en = 1'b1;
				end else begin
					raddr0 = BAW'(parent >> 1);
					raddr1 = BAW'(parent >> 1);
				end
			end
			SU_CMP: begin
				wr_en = 1'b1;
				if (par_data > v_q) begin
					wr_data = par_data;
				end
			end
			SD_RD: begin
				if (c1 >= count_x) begin
					wr_en = 1'b1;
				end else begin
					raddr1 = BAW'(hole_q);
					raddr0 = (c2 < count_x) ? BAW'(hole_p1) : BAW'(hole_q);
				end
			end
			SD_CMP: begin
				wr_en = 1'b1;
				if (small_data < v_q) begin
					wr_data = small_data;
				end
			end
			default: begin
			end
		endcase
		we0   = wr_en && !wr_idx[0];
		we1   = wr_en && wr_idx[0];
		waddr = BAW'(wr_idx >> 1);
	end

	// even heap positions
	rtks_ram #(.WIDTH(VALUE_W), .DEPTH(BD)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (wr_data),
		.raddr (raddr0),
		.rdata (rd0)
	);

	// odd heap positions
	rtks_ram #(.WIDTH(VALUE_W), .DEPTH(BD)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (wr_data),
		.raddr (raddr1),
		.rdata (rd1)
	);

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			top_q       <= CFG_RESET;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			v_q         <= '0;
			hole_q      <= '0;
			par_q       <= '0;
			c2v_q       <= 1'b0;
			prior_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				top_q <= cfg_wr_data;
			end
			// result beat held until taken; a new one only loads from IDLE
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (sums.valid && sums.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						prior_q <= base_sum;
						v_q     <= samples.sample_value;
						count_q <= has_room ? base_cnt + CW'(1) : base_cnt;
						sum_q   <= has_room ? base_sum + widen(samples.sample_value)
							: base_sum;
						if (has_room) begin
							hole_q  <= AW'(base_cnt);
							state_q <= SU_RD;
						end else if (base_cnt != '0) begin
							state_q <= RT_RD;
						end
					end
				end
				// sift up: compare with parent
				SU_RD: begin
					if (hole_q == '0) begin
						state_q <= IDLE;
					end else begin
						par_q   <= parent;
						state_q <= SU_CMP;
					end
				end
				SU_CMP: begin
					if (par_data > v_q) begin
						hole_q  <= par_q;
						state_q <= SU_RD;
					end else begin
						state_q <= IDLE;
					end
				end
				// replace the minimum if the new sample beats it
				RT_RD: begin
					state_q <= RT_CMP;
				end
				RT_CMP: begin
					if (rd0 < v_q) begin
						sum_q   <= sum_q + widen(v_q) - widen(rd0);
						hole_q  <= '0;
						state_q <= SD_RD;
					end else begin
						state_q <= IDLE;
					end
				end
				// sift down: pick the smaller child
				SD_RD: begin
					if (c1 >= count_x) begin
						state_q <= IDLE;
					end else begin
						c2v_q   <= c2 < count_x;
						state_q <= SD_CMP;
					end
				end
				SD_CMP: begin
					if (small_data < v_q) begin
						hole_q  <= small_idx;
						state_q <= SD_RD;
					end else begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_running_top_k_sum_top.sv =====
`timescale 1ns / 100ps

module tb_running_top_k_sum_top;
	import rtks_pkg::*;

	localparam int STORE          = STORE_SIZE_DEF;
	localparam int SETTLE_CYCLES  = 20;    // lets the heap walk finish, plus margin
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	rtks_in_if  samples ();
	rtks_out_if sums ();

	running_top_k_sum_top #(.STORE_SIZE(STORE)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.samples     (samples),
		.sums        (sums)
	);

	// top-k state mirrored on this side
	logic signed [VALUE_W-1:0] held_vals [STORE];
	int                        held_n = 0;
	logic signed [SUM_W-1:0]   kept_total = '0;
	logic [CFG_W-1:0]          keep_limit = CFG_RESET;

	logic signed [SUM_W-1:0] sum_expect_q [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int samples_sent = 0;
	int group_starts = 0;
	int sums_checked = 0;

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ERROR %s", $time, msg);
		mismatches++;
	endtask

	// sum before admitting v, then admit it into the kept set
	function automatic logic signed [SUM_W-1:0] admit_sample(
		input logic signed [VALUE_W-1:0] v, input logic sg);
		int cap;
		int lo_at;
		logic signed [SUM_W-1:0] prior;
		logic signed [SUM_W-1:0] v_wide;
		logic signed [SUM_W-1:0] lo_wide;
		cap = (int'(keep_limit) > STORE) ? STORE : int'(keep_limit);
		v_wide = v;
		if (sg) begin
			held_n = 0;
			kept_total = '0;
		end
		prior = kept_total;
		if (held_n < cap) begin
			held_vals[held_n] = v;
			held_n++;
			kept_total = kept_total + v_wide;
		end else if (held_n > 0) begin
			lo_at = 0;
			for (int i = 1; i < held_n; i++)
				if (held_vals[i] < held_vals[lo_at])
					lo_at = i;
			if (held_vals[lo_at] < v) begin
				lo_wide = held_vals[lo_at];
				kept_total = kept_total + v_wide - lo_wide;
				held_vals[lo_at] = v;
			end
		end
		return prior;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) begin
			case ($urandom_range(3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return '0;
				default: return '1;
			endcase
		end else if (sel <= 3) begin
			return $signed($urandom_range(200)) - 100;
		end
		return $urandom;
	endfunction

	// sink side: random stalls, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			sums.ready <= 1'b0;
		end else begin
			sums.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result check against the oldest expected sum
	always @(posedge clk) begin
		if (arst_n && sums.valid && sums.ready) begin
			if (sum_expect_q.size() == 0) begin
				report_mismatch($sformatf("sum beat %0d with nothing expected", sums.prior_sum));
			end else begin
				logic signed [SUM_W-1:0] want;
				want = sum_expect_q.pop_front();
				if (sums.prior_sum !== want)
					report_mismatch($sformatf("prior_sum got %0d expected %0d",
						sums.prior_sum, want));
				sums_checked++;
			end
		end
	end

	// watchdog: cycles with no beat on either channel
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (sums.valid && sums.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d cycles without a beat", idle_cycles);
				$display("tb_running_top_k_sum_top failed");
				$finish;
			end
		end
	end

	// one sample beat; valid is left high, the next call or the caller lowers it
	task automatic send_sample(input logic signed [VALUE_W-1:0] v, input logic sg);
		logic signed [SUM_W-1:0] want_sum;
		while ($urandom_range(99) < idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid        <= 1'b1;
		samples.sample_value <= v;
		samples.start_group  <= sg;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		want_sum = admit_sample(v, sg);
		sum_expect_q = {sum_expect_q, want_sum};
		samples_sent++;
		if (sg)
			group_starts++;
	endtask

	// register write once the block has drained
	task automatic set_top_count(input logic [CFG_W-1:0] n);
		samples.valid <= 1'b0;
		while (sum_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		keep_limit = n;
	endtask

	task automatic test_reset_count();
		idle_pct = 0;
		stall_pct = 0;
		send_sample(5, 1'b1);
		send_sample(-3, 1'b0);
		send_sample(VAL_MAX, 1'b0);
		send_sample(VAL_MIN, 1'b0);
	endtask

	task automatic test_value_extremes();
		set_top_count(7'd64);
		send_sample(VAL_MAX, 1'b1);
		send_sample(VAL_MAX, 1'b0);
		send_sample(VAL_MAX, 1'b0);
		send_sample(VAL_MIN, 1'b0);
		send_sample(VAL_MIN, 1'b0);
		send_sample(-1, 1'b0);
	endtask

	task automatic test_zero_count();
		set_top_count(7'd0);
		send_sample(7, 1'b1);
		send_sample(9, 1'b0);
	endtask

	// count dropped mid-group: held values stay, only strict replacement
	task automatic test_count_lowered();
		set_top_count(7'd4);
		send_sample(10, 1'b1);
		send_sample(20, 1'b0);
		send_sample(30, 1'b0);
		send_sample(40, 1'b0);
		set_top_count(7'd1);
		send_sample(15, 1'b0);
		send_sample(5, 1'b0);
		set_top_count(7'd0);
		send_sample(100, 1'b0);
		send_sample(-5, 1'b0);
	endtask

	// groups of random length; some long enough to overrun the store
	task automatic test_random_groups(input logic [CFG_W-1:0] n, input int items,
		input int idle, input int stall);
		int run;
		logic sg;
		set_top_count(n);
		idle_pct = idle;
		stall_pct = stall;
		run = 0;
		for (int left = items; left > 0; left--) begin
			if (run == 0) begin
				run = ($urandom_range(7) == 0) ? $urandom_range(100, 66) : $urandom_range(20, 1);
				// first group of a phase may carry on from before the write
				sg = (left != items) || ($urandom_range(1) == 1);
			end else begin
				sg = ($urandom_range(99) < 4);
			end
			run--;
			send_sample(pick_value(), sg);
		end
	endtask

	// sink holds off while samples keep coming, so the input backs up
	task automatic test_sink_hold_off();
		set_top_count(7'd10);
		idle_pct = 0;
		stall_pct = 0;
		hold_asks++;
		for (int i = 0; i < 40; i++)
			send_sample(pick_value(), i == 0);
	endtask

	initial begin
		cfg_wr_en            <= 1'b0;
		cfg_wr_data          <= '0;
		samples.valid        <= 1'b0;
		samples.sample_value <= '0;
		samples.start_group  <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_count();
		test_value_extremes();
		test_zero_count();
		test_count_lowered();
		test_random_groups(7'd1, 150, 0, 0);
		test_random_groups(7'd64, 200, 80, 0);
		test_random_groups(7'd127, 200, 0, 80);
		test_random_groups(7'd7, 200, 12, 12);
		test_random_groups(7'd33, 150, 0, 0);
		test_random_groups(7'd2, 150, 12, 12);
		test_random_groups(7'd0, 60, 0, 0);
		test_sink_hold_off();

		// drain
		samples.valid <= 1'b0;
		while (sum_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d samples in %0d groups, %0d sums checked",
			samples_sent, group_starts, sums_checked);
		$display("counts 0 to 127, value extremes, idling on both sides, %0d-cycle sink hold-off",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("tb_running_top_k_sum_top passed");
		else
			$display("tb_running_top_k_sum_top failed");
		$finish;
	end

endmodule
